// File: rtl/core/chs_pkg.sv
// types, constants and command/status structs for the consistent-hash endpoint selector
package chs_pkg;

	localparam int MAX_ENDPOINTS = 64;
	localparam int RING_DEPTH    = 8192;

	localparam int ADDR_W   = $clog2(RING_DEPTH);
	localparam int COUNT_W  = 14;
	localparam int EP_W     = 6;
	localparam int EPCNT_W  = 7;
	localparam int HASH_W   = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;
	localparam int BITCNT_W = $clog2(HASH_W);

	localparam logic [HASH_W-1:0] FNV_BASIS     = 64'hcbf29ce484222325;
	// prime is 2^40 + 435
	localparam int                FNV_PRIME_SHL = 40;
	localparam logic [8:0]        FNV_PRIME_LOW = 9'd435;

	localparam logic [CFG_IDX_W-1:0] CFG_EP_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_ENTRIES = 2'd1;

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_KEY    = 2'd1,
		ACT_SELECT = 2'd2,
		ACT_NONE   = 2'd3
	} chs_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMPARE,
		ST_OWNER,
		ST_MODULO,
		ST_RESULT
	} chs_state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [ADDR_W-1:0] entry_slot;
		logic [HASH_W-1:0] entry_hash;
		logic [EP_W-1:0]   entry_endpoint;
		logic [7:0]        key_byte;
		logic              key_last;
	} chs_item_t;

	typedef struct packed {
		logic [EP_W-1:0]   chosen_ep;
		logic [HASH_W-1:0] key_digest;
		logic              via_ring;
	} chs_result_t;

	typedef struct packed {
		logic accept;
		logic compare;
		logic owner;
		logic mod_step;
	} chs_cmd_t;

	typedef struct packed {
		logic start_ring;
		logic start_mod;
		logic len_zero;
		logic mod_last;
	} chs_status_t;

	function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
		input logic [7:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-8){1'b0}}, b};
		return (x << FNV_PRIME_SHL) + (x * {{(HASH_W-9){1'b0}}, FNV_PRIME_LOW});
	endfunction

endpackage

// File: rtl/core/chs_ctrl.sv
// sequencing state machine for key hashing, ring search and round-robin remainder
module chs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  chs_pkg::chs_status_t status,
	output chs_pkg::chs_cmd_t    cmd,
	output logic                busy,
	output logic                done
);
	import chs_pkg::*;

	chs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					if (status.start_ring) begin
						state_d = ST_SEARCH;
					end else if (status.start_mod) begin
						state_d = ST_MODULO;
					end
				end
			end
			ST_SEARCH: begin
				// table read issued here, registered data used in the next state
				state_d = status.len_zero ? ST_OWNER : ST_COMPARE;
			end
			ST_COMPARE: begin
				cmd.compare = 1'b1;
				state_d     = ST_SEARCH;
			end
			ST_OWNER: begin
				cmd.owner = 1'b1;
				state_d   = ST_RESULT;
			end
			ST_MODULO: begin
				cmd.mod_step = 1'b1;
				if (status.mod_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/chs_datapath.sv
// hash, ring table, lower-bound search registers and bit-serial remainder unit
module chs_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  chs_pkg::chs_item_t                     item,
	input  logic                                   cfg_we,
	input  logic [chs_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [chs_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  chs_pkg::chs_cmd_t                      cmd,
	output chs_pkg::chs_status_t                   status,
	output chs_pkg::chs_result_t                   result
);
	import chs_pkg::*;

	logic [HASH_W-1:0]   run_hash_q;
	logic [HASH_W-1:0]   rot_q;
	logic [EPCNT_W-1:0]  ep_cnt_q;
	logic [COUNT_W-1:0]  ring_n_q;

	logic [HASH_W-1:0]   key_q;
	logic [COUNT_W-1:0]  lo_q;
	logic [COUNT_W-1:0]  len_q;
	logic [HASH_W-1:0]   div_q;
	logic [EP_W-1:0]     rem_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic [EP_W-1:0]     ep_q;
	logic                via_q;

	logic [HASH_W+EP_W-1:0] ring_mem [RING_DEPTH];
	logic [HASH_W+EP_W-1:0] rd_q;
	logic [HASH_W-1:0]      rd_hash;
	logic [EP_W-1:0]        rd_owner;

	logic [COUNT_W-1:0]  ring_n;
	logic [EPCNT_W-1:0]  modulus;
	logic [COUNT_W-1:0]  half;
	logic [COUNT_W-1:0]  probe;
	logic [ADDR_W-1:0]   fin_idx;
	logic [ADDR_W-1:0]   rd_addr;
	logic [HASH_W-1:0]   hash_next;
	logic [EPCNT_W-1:0]  rem_shift;
	logic [EPCNT_W-1:0]  rem_next;
	logic                is_final_key;

	assign ring_n  = (ring_n_q > COUNT_W'(RING_DEPTH)) ? COUNT_W'(RING_DEPTH) : ring_n_q;
	assign modulus = (ep_cnt_q == '0) ? EPCNT_W'(1) :
		(ep_cnt_q > EPCNT_W'(MAX_ENDPOINTS)) ? EPCNT_W'(MAX_ENDPOINTS) : ep_cnt_q;

	assign hash_next    = fnv_mix(run_hash_q, item.key_byte);
	assign is_final_key = (item.action == ACT_KEY) && item.key_last;

	assign status.start_ring = is_final_key && (ring_n != '0);
	assign status.start_mod  = (item.action == ACT_SELECT) || (is_final_key && (ring_n == '0));
	assign status.len_zero   = (len_q == '0);
	assign status.mod_last   = (bit_cnt_q == '1);

	// lower-bound probe address, or the final hit with wrap to entry 0
	assign half    = len_q >> 1;
	assign probe   = lo_q + half;
	assign fin_idx = (lo_q >= ring_n) ? '0 : lo_q[ADDR_W-1:0];
	assign rd_addr = status.len_zero ? fin_idx : probe[ADDR_W-1:0];

	assign rd_hash  = rd_q[HASH_W+EP_W-1:EP_W];
	assign rd_owner = rd_q[EP_W-1:0];

	// one remainder bit per cycle, msb of the counter first
	assign rem_shift = {rem_q, div_q[HASH_W-1]};
	assign rem_next  = (rem_shift >= modulus) ? (rem_shift - modulus) : rem_shift;

	always_ff @(posedge clk) begin
		if (cmd.accept && (item.action == ACT_WRITE)) begin
			ring_mem[item.entry_slot] <= {item.entry_hash, item.entry_endpoint};
		end
		rd_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_hash_q <= FNV_BASIS;
			rot_q      <= '0;
			ep_cnt_q   <= EPCNT_W'(1);
			ring_n_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_EP_COUNT:     ep_cnt_q <= cfg_data[EPCNT_W-1:0];
					CFG_RING_ENTRIES: ring_n_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				case (item.action)
					ACT_KEY:    run_hash_q <= item.key_last ? FNV_BASIS : hash_next;
					ACT_SELECT: run_hash_q <= FNV_BASIS;
					default: ;
				endcase
				if (status.start_mod) begin
					rot_q <= rot_q + HASH_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q     <= (item.action == ACT_SELECT) ? FNV_BASIS : hash_next;
			lo_q      <= '0;
			len_q     <= ring_n;
			div_q     <= rot_q;
			rem_q     <= '0;
			bit_cnt_q <= '0;
			via_q     <= status.start_ring;
		end
		if (cmd.compare) begin
			if (rd_hash < key_q) begin
				lo_q  <= probe + COUNT_W'(1);
				len_q <= len_q - half - COUNT_W'(1);
			end else begin
				len_q <= half;
			end
		end
		if (cmd.owner) begin
			ep_q <= rd_owner;
		end
		if (cmd.mod_step) begin
			rem_q     <= rem_next[EP_W-1:0];
			div_q     <= div_q << 1;
			bit_cnt_q <= bit_cnt_q + BITCNT_W'(1);
			if (status.mod_last) begin
				ep_q <= rem_next[EP_W-1:0];
			end
		end
	end

	assign result.chosen_ep  = ep_q;
	assign result.key_digest = key_q;
	assign result.via_ring   = via_q;

endmodule

// File: rtl/core/consistent_hash_endpoint_select.sv
// top level of the consistent-hash endpoint selector
//
//   channel   handshake              payload
//   input     start / busy           item   (chs_item_t)
//   result    done (one-cycle pulse) result (chs_result_t)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// ring writes and non-final key bytes leave busy low, so the next item can follow at once
// final key byte with a ring: busy through k search probes (at most 14), then the owner
//   read and the result; each probe a registered read of the ring table plus a compare
// keyless select or final byte with no ring: busy while the remainder of the 64-bit
//   rotation counter is taken one bit per cycle
// reset clears the controller, rotation counter and ring size, presets the running hash
//   and endpoint count, not the table. done shows for one cycle and cannot be stalled
module consistent_hash_endpoint_select (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  chs_pkg::chs_item_t             item,
	output logic                           done,
	output chs_pkg::chs_result_t           result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [chs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [chs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import chs_pkg::*;

	chs_cmd_t    cmd;
	chs_status_t status;

	assign cfg_ready = 1'b1;

	chs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	chs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not followed by idle");

	a_key_byte_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ACT_KEY && !item.key_last) |=> !busy && !done)
		else $error("non-final key byte stalled or produced a result");

	a_select_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ACT_SELECT) |=> busy && !done)
		else $error("keyless select did not start the remainder unit");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.action == ACT_WRITE || item.action == ACT_NONE))
		|=> !busy && !done)
		else $error("table write or unused action caused activity");
`endif

endmodule
